@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

@@ hw/rtl/gbn_pkg.sv @@
package gbn_pkg;

  localparam int WIN_BITS         = 10;
  localparam int DEF_SEQ_BITS     = 16;
  localparam int DEF_BUFFER_SLOTS = 1024;

  localparam logic [WIN_BITS-1:0] WIN_MAX      = 10'd1023;
  localparam logic [WIN_BITS-1:0] WIN_ONE      = 10'd1;
  localparam logic [WIN_BITS-1:0] RST_INIT_WIN = 10'd3;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SEND = 2'd1,
    ACT_RETX = 2'd2,
    ACT_DONE = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    CFG_TOTAL    = 1'b0,
    CFG_INIT_WIN = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e action;
    logic    timer_restart;
  } step_ctl_t;

  // A zero window loads as one.
  function automatic logic [WIN_BITS-1:0] load_window(input logic [WIN_BITS-1:0] w);
    return (w == '0) ? WIN_ONE : w;
  endfunction

endpackage

@@ hw/rtl/gbn_step.sv @@
module gbn_step import gbn_pkg::*; #(
  parameter int SEQ_BITS     = DEF_SEQ_BITS,
  parameter int BUFFER_SLOTS = DEF_BUFFER_SLOTS,
  parameter int AW           = ((SEQ_BITS > WIN_BITS + 1) ? SEQ_BITS : WIN_BITS + 1) + 1
) (
  input  logic [1:0]          cmd_i,
  input  logic [SEQ_BITS-1:0] ack_i,
  input  logic [SEQ_BITS-1:0] total_i,
  input  logic [SEQ_BITS-1:0] base_i,
  input  logic [SEQ_BITS-1:0] next_i,
  input  logic [AW-1:0]       limit_i,
  input  logic [WIN_BITS-1:0] win_i,
  input  logic                done_i,
  output logic [SEQ_BITS-1:0] base_o,
  output logic [SEQ_BITS-1:0] next_o,
  output logic [AW-1:0]       limit_o,
  output logic [WIN_BITS-1:0] win_o,
  output logic                done_o,
  output step_ctl_t           ctl_o,
  output logic [SEQ_BITS-1:0] send_seq_o,
  output logic [SEQ_BITS-1:0] retx_first_o,
  output logic [SEQ_BITS-1:0] retx_end_o
);

  logic [SEQ_BITS-1:0] in_flight;
  logic [AW-1:0]       base_x;
  logic [AW-1:0]       next_x;
  logic                can_send;
  logic                ack_hit;
  logic                moved;
  logic                clamp;
  logic [WIN_BITS:0]   win_twice;
  logic [WIN_BITS-1:0] win_dbl;
  logic [WIN_BITS-1:0] win_retx;

  assign in_flight = next_i - base_i;
  assign base_x    = AW'(base_i);
  assign next_x    = AW'(next_i);

  assign can_send = (AW'(in_flight) < AW'(win_i)) && (next_i <= total_i) && (next_i != '1);
  assign ack_hit  = (ack_i >= base_i) && (AW'(ack_i) < limit_i) && (ack_i < next_i);

  // Keep the window when twice it would overrun the slot count or the field.
  assign win_twice = {win_i, 1'b0};
  assign win_dbl   = ((int'(win_twice) < BUFFER_SLOTS) && (win_twice <= {1'b0, WIN_MAX}))
                   ? win_twice[WIN_BITS-1:0] : win_i;

  // Retransmit end: stop at next sequence for a short outstanding run,
  // and never past what was sent.
  assign moved = (base_x != limit_i);
  assign clamp = (moved ? (base_x + AW'(win_i >> 1) > next_x)
                        : (base_x + AW'(win_twice) > next_x))
               || (limit_i > next_x);
  assign win_retx = (moved && (win_i != WIN_ONE)) ? (win_i >> 1) : win_dbl;

  always_comb begin
    base_o              = base_i;
    next_o              = next_i;
    limit_o             = limit_i;
    win_o               = win_i;
    done_o              = done_i;
    ctl_o.action        = ACT_NONE;
    ctl_o.timer_restart = 1'b0;
    send_seq_o          = '0;
    retx_first_o        = '0;
    retx_end_o          = '0;
    if (done_i) begin
      ctl_o.action = ACT_DONE;
    end else begin
      case (cmd_i)
        CMD_SEND: begin
          if (can_send) begin
            ctl_o.action        = ACT_SEND;
            ctl_o.timer_restart = (base_i == next_i);
            send_seq_o          = next_i;
            next_o              = next_i + SEQ_BITS'(1);
            limit_o             = AW'(next_i + SEQ_BITS'(1));
          end
        end
        CMD_ACK: begin
          if (ack_hit) begin
            base_o              = ack_i + SEQ_BITS'(1);
            ctl_o.timer_restart = 1'b1;
          end
          if (ack_i == total_i) begin
            done_o       = 1'b1;
            ctl_o.action = ACT_DONE;
          end
        end
        CMD_TIMEOUT: begin
          if (base_i != next_i) begin
            ctl_o.action        = ACT_RETX;
            ctl_o.timer_restart = 1'b1;
            retx_first_o        = base_i;
            retx_end_o          = clamp ? next_i : limit_i[SEQ_BITS-1:0];
            win_o               = win_retx;
            limit_o             = base_x + AW'(win_retx);
          end else begin
            win_o = win_dbl;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/gbn_out_reg.sv @@
module gbn_out_reg import gbn_pkg::*; #(
  parameter int SEQ_BITS = DEF_SEQ_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  step_ctl_t           ctl_i,
  input  logic [SEQ_BITS-1:0] send_seq_i,
  input  logic [SEQ_BITS-1:0] retx_first_i,
  input  logic [SEQ_BITS-1:0] retx_end_i,
  input  logic [WIN_BITS-1:0] win_i,
  input  logic                stall_i,
  output logic                valid_o,
  output step_ctl_t           ctl_o,
  output logic [SEQ_BITS-1:0] send_seq_o,
  output logic [SEQ_BITS-1:0] retx_first_o,
  output logic [SEQ_BITS-1:0] retx_end_o,
  output logic [WIN_BITS-1:0] win_o
);

  logic valid_q;
  logic valid_d;

  // Load only when the slot is empty or draining this cycle.
  assign valid_d = load_i ? 1'b1 : (stall_i ? valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ctl_o        <= ctl_i;
      send_seq_o   <= send_seq_i;
      retx_first_o <= retx_first_i;
      retx_end_o   <= retx_end_i;
      win_o        <= win_i;
    end
  end

  assign valid_o = valid_q;

endmodule

@@ hw/rtl/go_back_n_window_sender_core.sv @@
// Sender-side window control for a go-back-N transfer. Each input word is one
// event (send opportunity, ack arrived, retransmit timer expired) and yields
// exactly one result word: a granted sequence number, a retransmit range
// [retx_first, retx_end), a completion mark, or nothing, plus the timer
// restart flag and the window size after the event. Throughput is one word
// per clock while the output side is not stalled; an event enters an input
// register, the window state is read and updated combinationally, and the
// result is captured in the output register, where it is held until the
// output side accepts it. The state update path (window compares, adds and
// a shift) is combinational between the two registers. The input stalls
// only while both registers are full and the output waits. Write
// total_packets and initial_window only while no word is in flight;
// initial_window reloads the window only before the first packet is
// granted.
module go_back_n_window_sender_core import gbn_pkg::*; #(
  parameter int BUFFER_SLOTS = DEF_BUFFER_SLOTS,
  parameter int SEQ_BITS     = DEF_SEQ_BITS,
  parameter int CFG_BITS     = (SEQ_BITS > WIN_BITS) ? SEQ_BITS : WIN_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [SEQ_BITS-1:0] ack_number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          action_o,
  output logic [SEQ_BITS-1:0] send_seq_o,
  output logic [SEQ_BITS-1:0] retx_first_o,
  output logic [SEQ_BITS-1:0] retx_end_o,
  output logic                timer_restart_o,
  output logic [WIN_BITS-1:0] window_now_o
);

  // Limit holds base + window, so it needs room above the sequence width.
  localparam int AW = ((SEQ_BITS > WIN_BITS + 1) ? SEQ_BITS : WIN_BITS + 1) + 1;

  // Input register.
  logic                in_valid_q;
  logic                in_valid_d;
  logic [1:0]          cmd_q;
  logic [SEQ_BITS-1:0] ack_q;
  logic                in_take;
  logic                advance;

  // Configuration and window state.
  logic [SEQ_BITS-1:0] total_q;
  logic [SEQ_BITS-1:0] base_q, base_d;
  logic [SEQ_BITS-1:0] next_q, next_d;
  logic [AW-1:0]       limit_q, limit_d;
  logic [WIN_BITS-1:0] win_q, win_d;
  logic                done_q, done_d;

  // Step results toward the output register.
  step_ctl_t           ctl_d;
  step_ctl_t           ctl_out;
  logic [SEQ_BITS-1:0] send_seq_d;
  logic [SEQ_BITS-1:0] retx_first_d;
  logic [SEQ_BITS-1:0] retx_end_d;

  // Advance the held word whenever the output slot is free or draining;
  // stall the input only when both registers are full and the output waits.
  assign advance    = in_valid_q && !(out_valid_o && out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_o && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_i;
      ack_q <= ack_number_i;
    end
  end

  gbn_step #(
    .SEQ_BITS     (SEQ_BITS),
    .BUFFER_SLOTS (BUFFER_SLOTS),
    .AW           (AW)
  ) u_step (
    .cmd_i        (cmd_q),
    .ack_i        (ack_q),
    .total_i      (total_q),
    .base_i       (base_q),
    .next_i       (next_q),
    .limit_i      (limit_q),
    .win_i        (win_q),
    .done_i       (done_q),
    .base_o       (base_d),
    .next_o       (next_d),
    .limit_o      (limit_d),
    .win_o        (win_d),
    .done_o       (done_d),
    .ctl_o        (ctl_d),
    .send_seq_o   (send_seq_d),
    .retx_first_o (retx_first_d),
    .retx_end_o   (retx_end_d)
  );

  // Commit the window state with each processed word; otherwise take
  // configuration writes. A late initial_window write leaves the window alone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      base_q     <= SEQ_BITS'(1);
      next_q     <= SEQ_BITS'(1);
      limit_q    <= AW'(1);
      win_q      <= load_window(RST_INIT_WIN);
      done_q     <= 1'b0;
    end else if (advance) begin
      base_q  <= base_d;
      next_q  <= next_d;
      limit_q <= limit_d;
      win_q   <= win_d;
      done_q  <= done_d;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOTAL: begin
          total_q <= cfg_data_i[SEQ_BITS-1:0];
        end
        CFG_INIT_WIN: begin
          if ((next_q == SEQ_BITS'(1)) && !done_q) begin
            win_q <= load_window(cfg_data_i[WIN_BITS-1:0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

  gbn_out_reg #(
    .SEQ_BITS (SEQ_BITS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .ctl_i        (ctl_d),
    .send_seq_i   (send_seq_d),
    .retx_first_i (retx_first_d),
    .retx_end_i   (retx_end_d),
    .win_i        (win_d),
    .stall_i      (out_stall_i),
    .valid_o      (out_valid_o),
    .ctl_o        (ctl_out),
    .send_seq_o   (send_seq_o),
    .retx_first_o (retx_first_o),
    .retx_end_o   (retx_end_o),
    .win_o        (window_now_o)
  );

  assign action_o        = ctl_out.action;
  assign timer_restart_o = ctl_out.timer_restart;

endmodule

@@ hw/rtl/gbn_checker.sv @@
`include "assert_macros.svh"

module gbn_checker import gbn_pkg::*; #(
  parameter int SEQ_BITS = DEF_SEQ_BITS
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [1:0]          action_o,
  input logic [SEQ_BITS-1:0] send_seq_o,
  input logic [SEQ_BITS-1:0] retx_first_o,
  input logic [SEQ_BITS-1:0] retx_end_o,
  input logic                timer_restart_o,
  input logic [WIN_BITS-1:0] window_now_o
);

  // Hold a stalled result word.
  `ASSERT_AT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) && $stable(send_seq_o) && $stable(retx_end_o), "stalled result word changed")

  // A grant carries a real packet number and no range.
  `ASSERT_AT(a_send_shape, clk_i, rst_ni, out_valid_o && (action_o == ACT_SEND) |-> (send_seq_o != '0) && (retx_first_o == '0) && (retx_end_o == '0), "malformed grant")

  // A retransmit range restarts the timer and never runs backward.
  `ASSERT_AT(a_retx_range, clk_i, rst_ni, out_valid_o && (action_o == ACT_RETX) |-> timer_restart_o && (retx_end_o >= retx_first_o) && (retx_first_o != '0), "bad retransmit range")

  // The window never reports empty.
  `ASSERT_NEVER(a_win_nonzero, clk_i, rst_ni, out_valid_o && (window_now_o == '0), "window reported as zero")

endmodule

bind go_back_n_window_sender_core gbn_checker #(.SEQ_BITS(SEQ_BITS)) u_gbn_checker (.*);

@@ test/gbn_window_checker.sv @@
module gbn_window_checker
  import gbn_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [0:0]              cfg_idx_i,
  input  logic [DEF_SEQ_BITS-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [1:0]              cmd_i,
  input  logic [DEF_SEQ_BITS-1:0] ack_number_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [1:0]              action_i,
  input  logic [DEF_SEQ_BITS-1:0] send_seq_i,
  input  logic [DEF_SEQ_BITS-1:0] retx_first_i,
  input  logic [DEF_SEQ_BITS-1:0] retx_end_i,
  input  logic                    timer_restart_i,
  input  logic [WIN_BITS-1:0]     window_now_i,
  output int unsigned             pending_o,
  output logic [DEF_SEQ_BITS-1:0] seq_base_o,
  output logic [DEF_SEQ_BITS-1:0] seq_next_o,
  output int unsigned             errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW = DEF_SEQ_BITS;
  localparam int BUFFER_SLOTS = DEF_BUFFER_SLOTS;
  localparam logic [SW-1:0] SEQ_TOP = {SW{1'b1}};

  typedef struct packed {
    action_e             action;
    logic [SW-1:0]       send_seq;
    logic [SW-1:0]       retx_first;
    logic [SW-1:0]       retx_end;
    logic                timer_restart;
    logic [WIN_BITS-1:0] window_now;
  } sender_word_t;

  // Window state of the sender, kept in step with every accepted event.
  logic [SW-1:0]       base_q;
  logic [SW-1:0]       next_q;
  logic [SW:0]         limit_q;
  logic [WIN_BITS-1:0] win_q;
  logic                done_q;
  logic [SW-1:0]       total_q;
  logic [WIN_BITS-1:0] init_win_q;

  sender_word_t result_fifo[$];
  int unsigned  mismatches = 0;

  assign errors_o = mismatches;

  function automatic void grow_window();
    if (2 * int'(win_q) < BUFFER_SLOTS && 2 * int'(win_q) <= int'(WIN_MAX)) win_q = win_q << 1;
  endfunction

  function automatic void apply_reg(logic [0:0] idx, logic [SW-1:0] data);
    if (idx == CFG_TOTAL) begin
      total_q = data;
    end else begin
      init_win_q = data[WIN_BITS-1:0];
      // the window only reloads before the first grant
      if (next_q == 1 && !done_q) win_q = (init_win_q == '0) ? WIN_ONE : init_win_q;
    end
  endfunction

  function automatic sender_word_t window_event(logic [1:0] cmd, logic [SW-1:0] ack);
    sender_word_t w;
    logic [SW:0]  span_end;
    logic         moved;
    w = '0;
    w.action = ACT_NONE;
    if (done_q) begin
      w.action = ACT_DONE;
    end else begin
      case (cmd)
        CMD_SEND: begin
          if (32'(next_q) - 32'(base_q) < 32'(win_q) && next_q <= total_q &&
              next_q != SEQ_TOP) begin
            w.timer_restart = (base_q == next_q);
            w.send_seq = next_q;
            next_q = next_q + 1'b1;
            limit_q = {1'b0, next_q};
            w.action = ACT_SEND;
          end
        end
        CMD_ACK: begin
          if (ack >= base_q && {1'b0, ack} < limit_q && ack < next_q) begin
            base_q = ack + 1'b1;
            w.timer_restart = 1'b1;
          end
          if (ack == total_q) begin
            done_q = 1'b1;
            w.action = ACT_DONE;
          end
        end
        CMD_TIMEOUT: begin
          if (base_q != next_q) begin
            span_end = limit_q;
            moved = ({1'b0, base_q} != limit_q);
            if (moved && 32'(base_q) + 32'(win_q >> 1) > 32'(next_q))
              span_end = {1'b0, next_q};
            else if (!moved && 32'(base_q) + 2 * 32'(win_q) > 32'(next_q))
              span_end = {1'b0, next_q};
            // never resend what was never sent
            if (span_end > {1'b0, next_q}) span_end = {1'b0, next_q};
            w.retx_first = base_q;
            w.retx_end = span_end[SW-1:0];
            w.timer_restart = 1'b1;
            w.action = ACT_RETX;
            if (moved && win_q != WIN_ONE) win_q = win_q >> 1;
            else grow_window();
            limit_q = {1'b0, base_q} + (SW+1)'(win_q);
          end else begin
            grow_window();
          end
        end
        default: ;
      endcase
    end
    w.window_now = win_q;
    return w;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sender_word_t want;
    if (!rst_ni) begin
      base_q     = 1;
      next_q     = 1;
      limit_q    = 1;
      win_q      = RST_INIT_WIN;
      done_q     = 1'b0;
      total_q    = '0;
      init_win_q = RST_INIT_WIN;
      result_fifo.delete();
    end else begin
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) result_fifo.push_back(window_event(cmd_i, ack_number_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_fifo.size() == 0) begin
          mismatches++;
          $error("result word with none pending, action %0d", action_i);
        end else begin
          want = result_fifo.pop_front();
          check_field("action", want.action, action_i);
          check_field("send_seq", want.send_seq, send_seq_i);
          check_field("retx_first", want.retx_first, retx_first_i);
          check_field("retx_end", want.retx_end, retx_end_i);
          check_field("timer_restart", want.timer_restart, timer_restart_i);
          check_field("window_now", want.window_now, window_now_i);
        end
      end
    end
    pending_o  <= result_fifo.size();
    seq_base_o <= base_q;
    seq_next_o <= next_q;
  end

endmodule

@@ test/tb_go_back_n_window_sender_core.sv @@
module tb_go_back_n_window_sender_core;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_pkg::*;

  localparam int SW = DEF_SEQ_BITS;
  // the block treats the fourth command code as a no-op
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [SW-1:0] SEQ_TOP = {SW{1'b1}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_idx = CFG_TOTAL;
  logic [SW-1:0]       cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          cmd = CMD_SEND;
  logic [SW-1:0]       ack = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          action;
  logic [SW-1:0]       send_seq;
  logic [SW-1:0]       retx_first;
  logic [SW-1:0]       retx_end;
  logic                timer_restart;
  logic [WIN_BITS-1:0] window_now;

  // Percent of cycles in which the sender idles or the receiver stalls.
  int unsigned   idle_pct = 0;
  int unsigned   stall_pct = 0;
  // Last total_packets written; random acks steer clear of it so the
  // transfer only completes when the finale asks for it.
  logic [SW-1:0] total_set = '0;

  int unsigned   pending;
  int unsigned   errors;
  logic [SW-1:0] seq_base;
  logic [SW-1:0] seq_next;

  go_back_n_window_sender_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .ack_number_i    (ack),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .action_o        (action),
    .send_seq_o      (send_seq),
    .retx_first_o    (retx_first),
    .retx_end_o      (retx_end),
    .timer_restart_o (timer_restart),
    .window_now_o    (window_now)
  );

  gbn_window_checker window_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .cmd_i           (cmd),
    .ack_number_i    (ack),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .action_i        (action),
    .send_seq_i      (send_seq),
    .retx_first_i    (retx_first),
    .retx_end_i      (retx_end),
    .timer_restart_i (timer_restart),
    .window_now_i    (window_now),
    .pending_o       (pending),
    .seq_base_o      (seq_base),
    .seq_next_o      (seq_next),
    .errors_o        (errors)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stall the result side at random; the rate follows the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("FAIL go_back_n_window_sender_core");
    $finish;
  end

  // Offer one event word: idle at random first, then hold the word until it
  // is taken. Valid stays high on return so back-to-back words need no dip.
  task automatic push_event(input logic [1:0] c, input logic [SW-1:0] a);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    ack      <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every result word is back, then let the
  // pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [SW-1:0] data);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == CFG_TOTAL) total_set = data;
  endtask

  // Ack numbers that mostly fall outside the outstanding range: duplicates,
  // acks just past what was sent, the extremes and plain noise.
  function automatic logic [SW-1:0] stray_ack();
    logic [SW-1:0] a;
    case ($urandom_range(4))
      0: a = '0;
      1: a = SEQ_TOP;
      2: a = seq_base - 1'b1;
      3: a = seq_next + SW'($urandom_range(3));
      default: a = SW'($urandom);
    endcase
    while (a == total_set) a = SW'($urandom);
    return a;
  endfunction

  // One random event, weighted toward a well-behaved transfer: grants,
  // acks inside the window, timeouts, and a little noise.
  task automatic random_event();
    int unsigned   pick;
    logic [SW-1:0] a;
    pick = $urandom_range(99);
    a = SW'($urandom);
    if (pick < 52) begin
      push_event(CMD_SEND, a);
    end else if (pick < 78) begin
      a = stray_ack();
      if (seq_next != seq_base) begin
        if ($urandom_range(1)) a = seq_next - 1'b1;
        else a = seq_base + SW'($urandom_range(32'(seq_next - seq_base) - 1));
        if (a == total_set) a = stray_ack();
      end
      push_event(CMD_ACK, a);
    end else if (pick < 86) begin
      push_event(CMD_ACK, stray_ack());
    end else if (pick < 97) begin
      push_event(CMD_TIMEOUT, a);
    end else begin
      push_event(CMD_UNKNOWN, a);
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: register corners, every command, and the special cases.
    idle_pct  = 28;
    stall_pct = 28;
    write_reg(CFG_INIT_WIN, '0);          // zero window loads as one
    push_event(CMD_SEND, SW'($urandom));  // no packets to send yet
    push_event(CMD_TIMEOUT, SW'($urandom)); // nothing in flight: grow only
    push_event(CMD_UNKNOWN, SW'($urandom));
    push_event(CMD_ACK, 16'd7);
    write_reg(CFG_INIT_WIN, 16'hFFFF);    // largest window, upper bits masked
    push_event(CMD_TIMEOUT, SW'($urandom)); // already at the cap: hold
    write_reg(CFG_INIT_WIN, 16'd1);
    write_reg(CFG_TOTAL, SEQ_TOP);
    push_event(CMD_SEND, SW'($urandom));
    push_event(CMD_SEND, SW'($urandom));  // window full
    push_event(CMD_TIMEOUT, SW'($urandom)); // window of one doubles
    push_event(CMD_SEND, SW'($urandom));
    push_event(CMD_SEND, SW'($urandom));
    push_event(CMD_ACK, 16'd0);           // below base
    push_event(CMD_ACK, 16'd1);
    push_event(CMD_ACK, 16'd40000);       // beyond what was sent
    push_event(CMD_TIMEOUT, SW'($urandom)); // window halves
    write_reg(CFG_INIT_WIN, 16'd500);     // too late to reload
    push_event(CMD_TIMEOUT, SW'($urandom));
    push_event(CMD_SEND, SW'($urandom));
    push_event(CMD_SEND, SW'($urandom));
    push_event(CMD_ACK, 16'd3);
    push_event(CMD_UNKNOWN, SW'($urandom));

    // Random phases, each with its own idling pattern and register setting.
    for (phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          write_reg(CFG_INIT_WIN, 16'h0200);
        end
        1: begin
          // cap the transfer a little past the next packet so grants run out
          idle_pct  = 60;
          stall_pct = 0;
          write_reg(CFG_TOTAL, (seq_next > 16'hFFEF) ? SEQ_TOP : seq_next + 16'd15);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 60;
          write_reg(CFG_TOTAL, SEQ_TOP);
          write_reg(CFG_INIT_WIN, '0);
        end
        default: begin
          idle_pct  = 28;
          stall_pct = 28;
          write_reg(CFG_INIT_WIN, SW'($urandom));
        end
      endcase
      repeat (450) begin
        random_event();
        if ($urandom_range(199) == 0) settle();
      end
    end

    // Ack everything, open the window wide, then grant one burst back to
    // back and ack it in full.
    settle();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(CFG_TOTAL, SEQ_TOP);
    settle();
    push_event(CMD_ACK, seq_next - 1'b1);
    repeat (10) push_event(CMD_TIMEOUT, SW'($urandom));
    repeat (64) push_event(CMD_SEND, SW'($urandom));
    settle();
    push_event(CMD_ACK, seq_next - 1'b1);

    // Finish the transfer and make sure nothing moves afterward.
    idle_pct  = 28;
    stall_pct = 28;
    push_event(CMD_SEND, SW'($urandom));
    push_event(CMD_TIMEOUT, SW'($urandom));
    push_event(CMD_ACK, SEQ_TOP);
    push_event(CMD_SEND, SW'($urandom));
    push_event(CMD_TIMEOUT, SW'($urandom));
    push_event(CMD_ACK, 16'd5);
    write_reg(CFG_INIT_WIN, 16'd7);
    push_event(CMD_SEND, SW'($urandom));
    push_event(CMD_UNKNOWN, SW'($urandom));

    settle();
    if (errors == 0) begin
      $display("PASS go_back_n_window_sender_core");
    end else begin
      $display("FAIL go_back_n_window_sender_core");
    end
    $finish;
  end

endmodule
